FILE: design/mlqts_pkg.sv
// Shared types and constants for the multilevel queue tick scheduler.
// Depends on nothing; every other design file but mlqts_ram imports it.
package mlqts_pkg;

    // Fixed field widths of the input and result words
    localparam int ID_W       = 4;
    localparam int BURST_W    = 8;
    localparam int Q_W        = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [Q_W-1:0] QUANTUM_RESET = 8'd3;

    // Item kinds and queue levels
    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;
    localparam logic CLASS_RR    = 1'b0;
    localparam logic CLASS_FCFS  = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_QUANTUM = 1'b0;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    proc_id;
        logic               queue_class;
        logic [BURST_W-1:0] burst;
    } item_t;

    typedef struct packed {
        logic            ran_valid;
        logic [ID_W-1:0] ran_id;
        logic            ran_queue;
        logic            finished;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_ID,
        ST_RD_WORK,
        ST_SHIFT
    } state_t;

endpackage

FILE: design/mlqts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mlqts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mlqts_cfg.sv
// APB-style register port holding the round-robin quantum.
// Depends on mlqts_pkg.
module mlqts_cfg
    import mlqts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [Q_W-1:0]        quantum
);

    logic [Q_W-1:0] quantum_reg;
    logic [Q_W-1:0] quantum_next;
    logic           wr_hit;

    // Write strobe on the access cycle of a write to the quantum register
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_QUANTUM);

    always_comb
    begin
        quantum_next = quantum_reg;
        if (wr_hit)
        begin
            quantum_next = pwdata[Q_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            quantum_reg <= quantum_next;
        end
    end

    // Read-back; addresses with paddr[2] set read as zero
    assign prdata  = (paddr[2] == REG_QUANTUM) ? CFG_DATA_W'(quantum_reg) : '0;
    assign pready  = 1'b1;
    assign quantum = quantum_reg;

endmodule

FILE: design/mlqts_sched.sv
// Scheduler core: control sequencer, counters and the two state memories
// (queue entries for both levels, remaining work per process).
// Depends on mlqts_pkg and mlqts_ram.
module mlqts_sched
    import mlqts_pkg::*;
#(
    parameter int NUM_PROCS  = 16,
    parameter int BURST_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  item_t          item,
    input  logic [Q_W-1:0] quantum,
    output logic           busy,
    output logic           done,
    output result_t        result
);

    localparam int IDX_W   = $clog2(NUM_PROCS);
    localparam int CNT_W   = $clog2(NUM_PROCS + 1);
    localparam int QA_W    = IDX_W + 1;
    localparam int Q_DEPTH = 2 * (1 << IDX_W);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       ring_count_reg, ring_count_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       fifo_count_reg, fifo_count_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [Q_W-1:0]         ql_reg, ql_next;
    logic [NUM_PROCS-1:0]   active_reg, active_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic                   cls_reg, cls_next;
    logic [IDX_W-1:0]       shift_reg, shift_next;
    result_t                result_reg, result_next;
    logic                   done_reg, done_next;

    // Memory ports
    logic                   q_we;
    logic [QA_W-1:0]        q_waddr, q_raddr;
    logic [ID_W-1:0]        q_wdata, q_rdata;
    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr, w_raddr;
    logic [BURST_BITS-1:0]  w_wdata, w_rdata;

    // Helpers
    logic                   accept;
    logic [IDX_W-1:0]       arr_idx;
    logic [BURST_BITS-1:0]  arr_work;
    logic                   arr_ok;
    logic                   tick_go;
    logic [IDX_W-1:0]       ptr_eff;
    logic [CNT_W:0]         tail_sum;
    logic [IDX_W-1:0]       tail_idx;
    logic [BURST_BITS-1:0]  work_dec;
    logic                   fin;
    logic [Q_W-1:0]         ql_dec;
    logic [CNT_W-1:0]       cnt_dec;
    logic [CNT_W-1:0]       ptr_inc;
    logic [CNT_W-1:0]       head_inc;
    logic [CNT_W-1:0]       shift_inc;

    mlqts_ram #(
        .WIDTH (ID_W),
        .DEPTH (Q_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mlqts_ram #(
        .WIDTH (BURST_BITS),
        .DEPTH (NUM_PROCS)
    ) u_work_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // Accept decode and arrival qualification
    assign accept   = start && (state_reg == ST_IDLE);
    assign arr_idx  = IDX_W'(item.proc_id);
    assign arr_work = BURST_BITS'(item.burst);
    assign arr_ok   = accept && (item.kind == KIND_ARRIVE)
                      && (32'(item.proc_id) < NUM_PROCS)
                      && (arr_work != '0) && !active_reg[arr_idx];
    assign tick_go  = accept && (item.kind == KIND_TICK);

    // Pointer, tail and counter arithmetic
    assign ptr_eff   = (CNT_W'(ptr_reg) >= ring_count_reg) ? '0 : ptr_reg;
    assign tail_sum  = (CNT_W+1)'(head_reg) + (CNT_W+1)'(fifo_count_reg);
    assign tail_idx  = (tail_sum >= (CNT_W+1)'(NUM_PROCS))
                       ? IDX_W'(tail_sum - (CNT_W+1)'(NUM_PROCS)) : IDX_W'(tail_sum);
    assign work_dec  = w_rdata - BURST_BITS'(1);
    assign fin       = (work_dec == '0);
    assign ql_dec    = ql_reg - Q_W'(1);
    assign cnt_dec   = ring_count_reg - CNT_W'(1);
    assign ptr_inc   = CNT_W'(ptr_reg) + CNT_W'(1);
    assign head_inc  = CNT_W'(head_reg) + CNT_W'(1);
    assign shift_inc = CNT_W'(shift_reg) + CNT_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_go && ((ring_count_reg != '0) || (fifo_count_reg != '0)))
                begin
                    state_next = ST_RD_ID;
                end
            end
            ST_RD_ID:
            begin
                state_next = ST_RD_WORK;
            end
            ST_RD_WORK:
            begin
                if ((cls_reg == CLASS_RR) && fin && (CNT_W'(ptr_reg) < cnt_dec))
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (shift_inc >= ring_count_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory ports and result
    always_comb
    begin
        ring_count_next = ring_count_reg;
        ptr_next        = ptr_reg;
        fifo_count_next = fifo_count_reg;
        head_next       = head_reg;
        ql_next         = ql_reg;
        active_next     = active_reg;
        id_next         = id_reg;
        cls_next        = cls_reg;
        shift_next      = shift_reg;
        result_next     = result_reg;
        done_next       = 1'b0;
        q_we            = 1'b0;
        q_waddr         = {CLASS_RR, shift_reg};
        q_wdata         = q_rdata;
        q_raddr         = {CLASS_RR, IDX_W'(CNT_W'(shift_reg) + CNT_W'(2))};
        w_we            = 1'b0;
        w_waddr         = arr_idx;
        w_wdata         = arr_work;
        w_raddr         = IDX_W'(q_rdata);

        case (state_reg)
            ST_IDLE:
            begin
                // Arrival: mark active, store work, enqueue if room
                if (arr_ok)
                begin
                    active_next[arr_idx] = 1'b1;
                    w_we = 1'b1;
                    if (item.queue_class == CLASS_RR)
                    begin
                        if (ring_count_reg < CNT_W'(NUM_PROCS))
                        begin
                            q_we            = 1'b1;
                            q_waddr         = {CLASS_RR, IDX_W'(ring_count_reg)};
                            q_wdata         = item.proc_id;
                            ring_count_next = ring_count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (fifo_count_reg < CNT_W'(NUM_PROCS))
                        begin
                            q_we            = 1'b1;
                            q_waddr         = {CLASS_FCFS, tail_idx};
                            q_wdata         = item.proc_id;
                            fifo_count_next = fifo_count_reg + CNT_W'(1);
                        end
                    end
                end
                // Tick: fetch the running id, or report idle at once
                if (tick_go)
                begin
                    if (ring_count_reg != '0)
                    begin
                        q_raddr  = {CLASS_RR, ptr_eff};
                        ptr_next = ptr_eff;
                        cls_next = CLASS_RR;
                    end
                    else if (fifo_count_reg != '0)
                    begin
                        q_raddr  = {CLASS_FCFS, head_reg};
                        cls_next = CLASS_FCFS;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
            end
            ST_RD_ID:
            begin
                // Queue word arrives; fetch its remaining work
                id_next = q_rdata;
            end
            ST_RD_WORK:
            begin
                // Run one slot and write the work back
                w_we        = 1'b1;
                w_waddr     = IDX_W'(id_reg);
                w_wdata     = work_dec;
                done_next   = 1'b1;
                result_next = '{ran_valid: 1'b1, ran_id: id_reg,
                                ran_queue: cls_reg, finished: fin};
                if (fin)
                begin
                    active_next[IDX_W'(id_reg)] = 1'b0;
                end
                if (cls_reg == CLASS_RR)
                begin
                    ql_next = ql_dec;
                    if (fin)
                    begin
                        ring_count_next = cnt_dec;
                        ql_next         = quantum;
                        if (CNT_W'(ptr_reg) >= cnt_dec)
                        begin
                            ptr_next = '0;
                        end
                        else
                        begin
                            // Close the gap: start the compaction sweep
                            shift_next = ptr_reg;
                            q_raddr    = {CLASS_RR, IDX_W'(ptr_inc)};
                        end
                    end
                    else if (ql_dec == '0)
                    begin
                        ql_next  = quantum;
                        ptr_next = (ptr_inc >= ring_count_reg) ? '0 : IDX_W'(ptr_inc);
                    end
                end
                else if (fin)
                begin
                    fifo_count_next = fifo_count_reg - CNT_W'(1);
                    head_next = (head_inc == CNT_W'(NUM_PROCS)) ? '0 : IDX_W'(head_inc);
                end
            end
            ST_SHIFT:
            begin
                // Entry i+1 read last cycle is written to entry i
                q_we       = 1'b1;
                shift_next = IDX_W'(shift_inc);
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ring_count_reg <= '0;
            ptr_reg        <= '0;
            fifo_count_reg <= '0;
            head_reg       <= '0;
            ql_reg         <= QUANTUM_RESET;
            active_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ring_count_reg <= ring_count_next;
            ptr_reg        <= ptr_next;
            fifo_count_reg <= fifo_count_next;
            head_reg       <= head_next;
            ql_reg         <= ql_next;
            active_reg     <= active_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        cls_reg    <= cls_next;
        shift_reg  <= shift_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: design/multilevel_queue_tick_scheduler_top.sv
// Top level of the multilevel queue tick scheduler: register port and core.
// Depends on mlqts_pkg, mlqts_cfg, mlqts_sched (and through it mlqts_ram).
//
// Usage:
//   Input words are taken on a rising edge with start high and busy low.
//   An arrival word (kind 0) registers a process id and its burst in the
//   round-robin ring or the FCFS queue; it gives no result. A tick word
//   (kind 1) runs one time slot and gives exactly one result word, shown
//   for one cycle with done high; the receiver cannot hold it off.
//   An idle tick (both levels empty) reports in the cycle after it is
//   taken. A tick that runs a process reports after the queue memory
//   read, then the work memory read, then the update. When a ring
//   process finishes in mid-ring, the ring is compacted one entry per
//   cycle after the result, with busy high until it is done. The two
//   registered memory reads set the tick rate.
//   The quantum register sits at byte address 0 and should be written
//   only while busy is low. Reset empties both levels, sets the quantum
//   to 3 and leaves the memories unset; no clearing pass is needed.
module multilevel_queue_tick_scheduler_top
    import mlqts_pkg::*;
#(
    parameter int NUM_PROCS  = 16,
    parameter int BURST_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  done,
    output result_t               result
);

    logic [Q_W-1:0] quantum;

    mlqts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .quantum (quantum)
    );

    mlqts_sched #(
        .NUM_PROCS  (NUM_PROCS),
        .BURST_BITS (BURST_BITS)
    ) u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .quantum (quantum),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // An arrival never produces a result in the following cycle
    a_arrive_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.kind == KIND_ARRIVE)) |=> !done)
        else $error("result word after an arrival");

    // An idle result carries all-zero fields
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ran_valid) |->
        ((result.ran_id == '0) && !result.ran_queue && !result.finished))
        else $error("idle result with non-zero fields");

    // A running result comes out of the memory sequence, so busy was high
    a_run_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.ran_valid) |-> $past(busy))
        else $error("running result without a preceding busy cycle");

    // An idle result answers a tick taken while not busy
    a_idle_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ran_valid) |->
        ($past(start) && !$past(busy) && ($past(item.kind) == KIND_TICK)))
        else $error("idle result without a tick taken");

endmodule

FILE: tb/tb_multilevel_queue_tick_scheduler_top.sv
// Self-checking testbench for the multilevel queue tick scheduler top level.
// Depends on mlqts_pkg and multilevel_queue_tick_scheduler_top; predicts every
// tick result in-line and checks it against the strobed result word.
module tb_multilevel_queue_tick_scheduler_top;
    import mlqts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PROC_SLOTS = 16;
    localparam int SETTLE_CYCLES = PROC_SLOTS + 6;
    localparam logic [CFG_ADDR_W-1:0] QUANTUM_ADDR  = {REG_QUANTUM, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] RESERVED_ADDR = {~REG_QUANTUM, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;

    // Scheduler image kept by the testbench
    logic [ID_W-1:0]    rr_ring [PROC_SLOTS];
    logic [4:0]         rr_count   = '0;
    logic [ID_W-1:0]    rr_ptr     = '0;
    logic [Q_W-1:0]     slice_left = QUANTUM_RESET;
    logic [ID_W-1:0]    fcfs_ring [PROC_SLOTS];
    logic [ID_W-1:0]    fcfs_head  = '0;
    logic [4:0]         fcfs_count = '0;
    logic [BURST_W-1:0] work_left [PROC_SLOTS];
    logic [15:0]        live_mask  = '0;
    logic [Q_W-1:0]     quantum_reg = QUANTUM_RESET;

    result_t pending_runs[$];
    int      gap_pct       = 0;
    int      fail_count    = 0;
    int      words_sent    = 0;
    int      words_dropped = 0;
    int      results_seen  = 0;
    int      finishes_seen = 0;
    int      idle_seen     = 0;

    multilevel_queue_tick_scheduler_top #(
        .NUM_PROCS  (PROC_SLOTS),
        .BURST_BITS (BURST_W)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40)
        begin
            $display("%0t ns: MISMATCH %s: got %0d, wanted %0d", $time, what, got, want);
        end
        fail_count++;
    endtask

    // Applies one accepted word to the scheduler image; queues the result of a
    // tick. Returns 0 for arrivals that the block ignores.
    function automatic bit run_scheduler(input item_t w);
        logic [ID_W-1:0] pid;
        logic [ID_W-1:0] tail;
        bit              fin;
        result_t         r;
        r = '0;
        if (w.kind == KIND_ARRIVE)
        begin
            // zero bursts and ids already live in either level are dropped
            if (w.burst == '0 || live_mask[w.proc_id])
                return 1'b0;
            live_mask[w.proc_id] = 1'b1;
            work_left[w.proc_id] = w.burst;
            if (w.queue_class == CLASS_RR)
            begin
                if (rr_count < PROC_SLOTS)
                begin
                    rr_ring[rr_count[ID_W-1:0]] = w.proc_id;
                    rr_count++;
                end
            end
            else if (fcfs_count < PROC_SLOTS)
            begin
                tail = fcfs_head + fcfs_count[ID_W-1:0];
                fcfs_ring[tail] = w.proc_id;
                fcfs_count++;
            end
            return 1'b1;
        end
        if (rr_count != 0)
        begin
            // ring level: one slot, then remove, rotate or keep the slice
            if (rr_ptr >= rr_count)
                rr_ptr = '0;
            pid = rr_ring[rr_ptr];
            work_left[pid] = work_left[pid] - 1'b1;
            slice_left = slice_left - 1'b1;
            fin = (work_left[pid] == '0);
            if (fin)
            begin
                for (int i = rr_ptr; i + 1 < rr_count; i++)
                    rr_ring[i] = rr_ring[i + 1];
                rr_count--;
                live_mask[pid] = 1'b0;
                slice_left = quantum_reg;
                if (rr_ptr >= rr_count)
                    rr_ptr = '0;
            end
            else if (slice_left == '0)
            begin
                rr_ptr++;
                slice_left = quantum_reg;
                if (rr_ptr >= rr_count)
                    rr_ptr = '0;
            end
            r.ran_valid = 1'b1;
            r.ran_id    = pid;
            r.ran_queue = CLASS_RR;
            r.finished  = fin;
        end
        else if (fcfs_count != 0)
        begin
            // FCFS level runs only on an empty ring; slice count untouched
            pid = fcfs_ring[fcfs_head];
            work_left[pid] = work_left[pid] - 1'b1;
            fin = (work_left[pid] == '0);
            if (fin)
            begin
                fcfs_head++;
                fcfs_count--;
                live_mask[pid] = 1'b0;
            end
            r.ran_valid = 1'b1;
            r.ran_id    = pid;
            r.ran_queue = CLASS_FCFS;
            r.finished  = fin;
        end
        pending_runs.insert(pending_runs.size(), r);
        return 1'b1;
    endfunction

    // Result word check, one per done strobe
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_runs.size() == 0)
            begin
                report_mismatch("result word with nothing pending", result, 0);
            end
            else
            begin
                want = pending_runs.pop_front();
                if (result.ran_valid !== want.ran_valid)
                    report_mismatch("ran_valid", result.ran_valid, want.ran_valid);
                if (result.ran_id !== want.ran_id)
                    report_mismatch("ran_id", result.ran_id, want.ran_id);
                if (result.ran_queue !== want.ran_queue)
                    report_mismatch("ran_queue", result.ran_queue, want.ran_queue);
                if (result.finished !== want.finished)
                    report_mismatch("finished", result.finished, want.finished);
                if (want.finished)
                    finishes_seen++;
                if (!want.ran_valid)
                    idle_seen++;
            end
        end
    end

    // Sends one word, idling the sender beforehand at random
    task automatic send_word(input item_t w, output bit took);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        took = run_scheduler(w);
        words_sent++;
    endtask

    function automatic item_t arrive_word(input int pid, input logic cls, input int burst);
        item_t w;
        w.kind        = KIND_ARRIVE;
        w.proc_id     = pid[ID_W-1:0];
        w.queue_class = cls;
        w.burst       = burst[BURST_W-1:0];
        return w;
    endfunction

    function automatic item_t tick_word();
        item_t w;
        w             = item_t'($urandom());
        w.kind        = KIND_TICK;
        return w;
    endfunction

    // Holds the sender off until every result is in and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == QUANTUM_ADDR)
            quantum_reg = data[Q_W-1:0];
        // bus idle between transfers
        @(posedge clk);
    endtask

    task automatic check_quantum_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= QUANTUM_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[Q_W-1:0] !== quantum_reg)
            report_mismatch("quantum readback", prdata[Q_W-1:0], quantum_reg);
        psel    <= 1'b0;
        penable <= 1'b0;
        // bus idle between transfers
        @(posedge clk);
    endtask

    task automatic set_quantum(input logic [Q_W-1:0] q);
        wait_idle();
        cfg_write(QUANTUM_ADDR, {{(CFG_DATA_W-Q_W){1'b0}}, q});
        check_quantum_readback();
    endtask

    // Idle ticks, dropped arrivals, quantum expiry and a finish in mid-ring
    task automatic test_fixed_cases();
        bit took;
        send_word(tick_word(), took);
        send_word(arrive_word(5, CLASS_RR, 0), took);
        send_word(tick_word(), took);
        send_word(arrive_word(3, CLASS_RR, 5), took);
        send_word(arrive_word(0, CLASS_RR, 2), took);
        send_word(arrive_word(15, CLASS_RR, 1), took);
        send_word(arrive_word(0, CLASS_RR, 255), took);
        send_word(arrive_word(0, CLASS_FCFS, 3), took);
        send_word(arrive_word(10, CLASS_FCFS, 2), took);
        repeat (12)
            send_word(tick_word(), took);
    endtask

    // Reset value, a write to the unused address, then a real write
    task automatic test_quantum_register();
        wait_idle();
        check_quantum_readback();
        cfg_write(RESERVED_ADDR, 32'hFFFF_FFA5);
        check_quantum_readback();
        cfg_write(QUANTUM_ADDR, 32'h0000_0001);
        check_quantum_readback();
    endtask

    // Random traffic in episodes of varying load; ignored arrivals are noise
    task automatic test_random_traffic(input int n_words, input int idle_pct, input bit drain_mid);
        int    sent;
        int    arrive_pct;
        int    pick;
        int    burst;
        bit    took;
        item_t w;
        sent       = 0;
        arrive_pct = 40;
        gap_pct    = idle_pct;
        while (sent < n_words)
        begin
            if (sent % 40 == 0)
                arrive_pct = $urandom_range(15, 75);
            if (drain_mid && sent == n_words / 2)
            begin
                wait_idle();
                drain_mid = 1'b0;
            end
            if ($urandom_range(0, 99) < arrive_pct)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    burst = 0;
                else if (pick < 70)
                    burst = $urandom_range(1, 6);
                else if (pick < 85)
                    burst = $urandom_range(7, 24);
                else
                    burst = $urandom_range(0, 255);
                w = arrive_word($urandom_range(0, 15), $urandom_range(0, 1), burst);
            end
            else
            begin
                w = tick_word();
            end
            send_word(w, took);
            sent++;
            if (!took)
                words_dropped++;
        end
        gap_pct = 0;
    endtask

    // Run time limit for the whole regression
    initial
    begin
        #5_000_000;
        $display("multilevel_queue_tick_scheduler_top regression: fail");
        $finish;
    end

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        item    = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fixed_cases();
        test_quantum_register();
        test_random_traffic(400, 35, 1'b0);
        set_quantum(8'd255);
        test_random_traffic(400, 77, 1'b1);
        set_quantum(8'd0);
        test_random_traffic(250, 0, 1'b0);
        set_quantum(Q_W'($urandom_range(2, 8)));
        test_random_traffic(480, 0, 1'b0);

        wait_idle();
        if (pending_runs.size() != 0)
            report_mismatch("results never delivered", pending_runs.size(), 0);

        $display("Sent %0d words (%0d random arrivals dropped), checked %0d results",
                 words_sent, words_dropped, results_seen);
        $display("Saw %0d finishes and %0d idle ticks; quanta 3, 1, 255, 0 and a small one",
                 finishes_seen, idle_seen);
        if (fail_count == 0)
            $display("multilevel_queue_tick_scheduler_top regression: pass");
        else
            $display("multilevel_queue_tick_scheduler_top regression: fail");
        $finish;
    end

endmodule
